// ===== design/aecc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Cursor controller package
// Shared constants, codes and handshake types of the escape cursor controller.
// ----------------------------------------------------------------------------
package aecc_pkg;

	localparam int MAX_ARGUMENTS_DEF = 8;
	localparam int MAX_SAVED_DEF     = 8;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CONSOLE = 2'd2;

	localparam logic [7:0] COLUMNS_RST = 8'd80;
	localparam logic [7:0] ROWS_RST    = 8'd25;

	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_BS       = 8'h08;
	localparam logic [7:0] CH_LF       = 8'h0A;
	localparam logic [7:0] CH_FF       = 8'h0C;
	localparam logic [7:0] CH_CR       = 8'h0D;
	localparam logic [7:0] CH_ESC      = 8'h1B;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_ZERO     = 8'h30;
	localparam logic [7:0] CH_NINE     = 8'h39;
	localparam logic [7:0] CH_SEMI     = 8'h3B;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_UP       = 8'h41;
	localparam logic [7:0] CH_DOWN     = 8'h42;
	localparam logic [7:0] CH_RIGHT    = 8'h43;
	localparam logic [7:0] CH_LEFT     = 8'h44;
	localparam logic [7:0] CH_NEXTLN   = 8'h45;
	localparam logic [7:0] CH_PREVLN   = 8'h46;
	localparam logic [7:0] CH_COLABS   = 8'h47;
	localparam logic [7:0] CH_HOME     = 8'h48;
	localparam logic [7:0] CH_HOME_F   = 8'h66;
	localparam logic [7:0] CH_SAVE     = 8'h73;
	localparam logic [7:0] CH_RESTORE  = 8'h75;
	localparam logic [7:0] CH_ERASE_LN = 8'h4B;
	localparam logic [7:0] CH_ERASE_SC = 8'h4A;
	localparam logic [7:0] CH_ATTR     = 8'h6D;

	localparam logic [2:0] CMD_PUT_CHAR     = 3'd0;
	localparam logic [2:0] CMD_CLEAR_LINE   = 3'd1;
	localparam logic [2:0] CMD_CLEAR_SCREEN = 3'd2;
	localparam logic [2:0] CMD_SET_ATTR     = 3'd3;
	localparam logic [2:0] CMD_SCROLL_UP    = 3'd4;
	localparam logic [2:0] CMD_MOVE_CURSOR  = 3'd5;

	typedef enum logic [1:0] {
		PH_TEXT,
		PH_ESC,
		PH_ARGS
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_ATTR,
		ST_WRAP,
		ST_MOVE
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic attr;
		logic wrap;
		logic move;
	} aecc_cmd_t;

	typedef struct packed {
		logic high_byte;
		logic attr_seq;
		logic attr_last;
		logic console;
		logic busy;
	} aecc_sts_t;

endpackage
`default_nettype wire

// ===== design/aecc_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Cursor controller channels
// Valid/ready channels for text bytes in and display commands out.
// ----------------------------------------------------------------------------
interface aecc_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;

	modport source (output valid, output text_byte, input ready);
	modport sink (input valid, input text_byte, output ready);
endinterface

interface aecc_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  command;
	logic [15:0] command_value;
	logic [7:0]  cursor_row;
	logic [7:0]  cursor_column;
	logic        last_command;

	modport source (output valid, output command, output command_value, output cursor_row,
		output cursor_column, output last_command, input ready);
	modport sink (input valid, input command, input command_value, input cursor_row,
		input cursor_column, input last_command, output ready);
endinterface
`default_nettype wire

// ===== design/ansi_escape_cursor_controller.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ANSI escape cursor controller
// Parses a text byte stream with ESC [ sequences and issues display commands.
// ----------------------------------------------------------------------------
// Usage:
//   text   : one ASCII byte per transfer (valid/ready). Bytes 0x80 and up are
//            dropped with no result.
//   result : display commands, each tagged with the cursor position; the
//            last command a byte causes carries last_command.
//   wr_en/wr_index/wr_data : screen_columns (0), screen_rows (1),
//            console_active (2); write only while no byte is in flight.
// Steps: one byte at a time. A byte steps through take, execute and wrap,
//   plus a move step when console_active is set, plus one set attribute
//   step per command of an m sequence (one per argument, at least one). A
//   high byte steps through take and execute only. The sequencer issues at
//   most one command per cycle, unless the result path is full, through a
//   pending stage and an output register.
// Reset: cursor at 0,0, text state, 80x25 screen, console_active set.
// Stall: a waiting result holds in the output register; once the pending
//   stage also fills, the sequencer holds; a byte is still taken when idle.
// ----------------------------------------------------------------------------
module ansi_escape_cursor_controller #(
	parameter int MAX_ARGUMENTS = aecc_pkg::MAX_ARGUMENTS_DEF,
	parameter int MAX_SAVED     = aecc_pkg::MAX_SAVED_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [aecc_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [aecc_pkg::CFG_DATA_W-1:0] wr_data,
	aecc_text_if.sink                       text,
	aecc_result_if.source                   result
);
	import aecc_pkg::*;

	aecc_cmd_t cmd;
	aecc_sts_t sts;

	aecc_ctl u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (text.valid),
		.in_ready (text.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	aecc_dp #(
		.MAX_ARGUMENTS (MAX_ARGUMENTS),
		.MAX_SAVED     (MAX_SAVED)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.text_byte     (text.text_byte),
		.cmd           (cmd),
		.sts           (sts),
		.out_ready     (result.ready),
		.out_valid     (result.valid),
		.command       (result.command),
		.command_value (result.command_value),
		.cursor_row    (result.cursor_row),
		.cursor_column (result.cursor_column),
		.last_command  (result.last_command)
	);

endmodule
`default_nettype wire

// ===== design/aecc_ctl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Cursor controller sequencer
// Steps each accepted byte through execute and, as needed, attribute, wrap and move phases.
// ----------------------------------------------------------------------------
module aecc_ctl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  aecc_pkg::aecc_sts_t sts,
	output aecc_pkg::aecc_cmd_t cmd
);
	import aecc_pkg::*;

	state_t state_q;
	state_t state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_n  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (!sts.busy) begin
					cmd.exec = 1'b1;
					if (sts.high_byte) begin
						state_n = ST_IDLE;
					end else if (sts.attr_seq) begin
						state_n = ST_ATTR;
					end else begin
						state_n = ST_WRAP;
					end
				end
			end
			ST_ATTR: begin
				if (!sts.busy) begin
					cmd.attr = 1'b1;
					if (sts.attr_last) begin
						state_n = ST_WRAP;
					end
				end
			end
			ST_WRAP: begin
				if (!sts.busy) begin
					cmd.wrap = 1'b1;
					state_n  = sts.console ? ST_MOVE : ST_IDLE;
				end
			end
			ST_MOVE: begin
				if (!sts.busy) begin
					cmd.move = 1'b1;
					state_n  = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_EXEC)
		else $error("accepted byte did not enter execute");

	a_move_console: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MOVE |-> sts.console)
		else $error("move step without console_active");

	a_no_step_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sts.busy |-> !(cmd.exec || cmd.attr || cmd.wrap || cmd.move))
		else $error("step issued while result path is full");

endmodule
`default_nettype wire

// ===== design/aecc_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Cursor controller datapath
// Configuration, escape state, cursor, save stack and result registers.
// ----------------------------------------------------------------------------
module aecc_dp #(
	parameter int MAX_ARGUMENTS = aecc_pkg::MAX_ARGUMENTS_DEF,
	parameter int MAX_SAVED     = aecc_pkg::MAX_SAVED_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [aecc_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [aecc_pkg::CFG_DATA_W-1:0]  wr_data,
	input  logic [7:0]                       text_byte,
	input  aecc_pkg::aecc_cmd_t              cmd,
	output aecc_pkg::aecc_sts_t              sts,
	input  logic                             out_ready,
	output logic                             out_valid,
	output logic [2:0]                       command,
	output logic [15:0]                      command_value,
	output logic [7:0]                       cursor_row,
	output logic [7:0]                       cursor_column,
	output logic                             last_command
);
	import aecc_pkg::*;

	localparam int AW = $clog2(MAX_ARGUMENTS);
	localparam int SW = $clog2(MAX_SAVED);

	logic [7:0]    cols_q;
	logic [7:0]    rows_q;
	logic          console_q;
	logic [7:0]    byte_q;
	phase_t        phase_q;
	phase_t        phase_n;
	logic [AW-1:0] cnt_q;
	logic [AW-1:0] cnt_n;
	logic [15:0]   args_q [MAX_ARGUMENTS];
	logic [7:0]    row_q;
	logic [7:0]    row_n;
	logic [7:0]    col_q;
	logic [7:0]    col_n;
	logic [15:0]   stack_q [MAX_SAVED];
	logic [SW-1:0] saved_q;
	logic [SW-1:0] saved_n;
	logic [AW-1:0] attr_q;
	logic [AW-1:0] attr_n;

	logic          pend_v_q;
	logic          pend_last_q;
	logic [2:0]    pend_cmd_q;
	logic [15:0]   pend_val_q;
	logic [7:0]    pend_row_q;
	logic [7:0]    pend_col_q;
	logic          out_v_q;
	logic          out_last_q;
	logic [2:0]    out_cmd_q;
	logic [15:0]   out_val_q;
	logic [7:0]    out_row_q;
	logic [7:0]    out_col_q;

	logic          arg_clr;
	logic          arg_we;
	logic          stk_we;
	logic          mark_last;
	logic          emit_now;
	logic          emit_last;
	logic [2:0]    emit_cmd;
	logic [15:0]   emit_val;
	logic [7:0]    emit_row;
	logic [7:0]    emit_col;
	logic          out_free;
	logic          busy;
	logic          push;

	logic          is_digit;
	logic [AW-1:0] dig_idx;
	logic [AW-1:0] rd_idx;
	logic [15:0]   arg_rd;
	logic [15:0]   arg_mac;
	logic [15:0]   n_cnt;
	logic [15:0]   n_dec0;
	logic [15:0]   n_dec1;
	logic [7:0]    up_row;
	logic [7:0]    lf_col;
	logic [16:0]   dn_sum;
	logic [16:0]   rt_sum;
	logic          dn_ok;
	logic          rt_ok;
	logic          g_ok;
	logic [7:0]    lim_r;
	logic [7:0]    lim_c;
	logic [7:0]    h_row;
	logic [7:0]    h_col;
	logic [8:0]    tab_t;
	logic          tab_wrap;
	logic [15:0]   stk_rd;
	logic          col_ovf;
	logic [7:0]    row_w;
	logic [7:0]    col_w;
	logic          scroll;

	assign out_free = !out_v_q || out_ready;
	assign busy     = pend_v_q && !out_free;
	assign push     = pend_v_q && out_free && (pend_last_q || emit_now);

	assign is_digit = (byte_q >= CH_ZERO) && (byte_q <= CH_NINE);
	assign dig_idx  = (cnt_q == '0) ? '0 : cnt_q - AW'(1);
	assign rd_idx   = cmd.attr ? attr_q : dig_idx;
	assign arg_rd   = args_q[rd_idx];
	assign arg_mac  = 16'({arg_rd, 3'b000} + {2'b00, arg_rd, 1'b0} + {15'd0, byte_q[3:0]});

	assign n_cnt  = (args_q[0] == 16'd0) ? 16'd1 : args_q[0];
	assign n_dec0 = (args_q[0] == 16'd0) ? 16'd0 : args_q[0] - 16'd1;
	assign n_dec1 = (args_q[1] == 16'd0) ? 16'd0 : args_q[1] - 16'd1;
	assign up_row = ({8'd0, row_q} >= n_cnt) ? row_q - n_cnt[7:0] : 8'd0;
	assign lf_col = ({8'd0, col_q} >= n_cnt) ? col_q - n_cnt[7:0] : 8'd0;
	assign dn_sum = {9'd0, row_q} + {1'b0, n_cnt};
	assign rt_sum = {9'd0, col_q} + {1'b0, n_cnt};
	assign dn_ok  = dn_sum < {9'd0, rows_q};
	assign rt_ok  = rt_sum < {9'd0, cols_q};
	assign g_ok   = n_dec0 < {8'd0, cols_q};
	assign lim_r  = (rows_q == 8'd0) ? 8'd0 : rows_q - 8'd1;
	assign lim_c  = (cols_q == 8'd0) ? 8'd0 : cols_q - 8'd1;
	assign h_row  = (n_dec0 > {8'd0, lim_r}) ? lim_r : n_dec0[7:0];
	assign h_col  = (n_dec1 > {8'd0, lim_c}) ? lim_c : n_dec1[7:0];

	assign tab_t    = ({1'b0, col_q} + 9'd8) & 9'h1F8;
	assign tab_wrap = tab_t >= {1'b0, cols_q};
	assign stk_rd   = stack_q[saved_q - SW'(1)];

	assign col_ovf = col_q >= cols_q;
	assign row_w   = col_ovf ? row_q + 8'd1 : row_q;
	assign col_w   = col_ovf ? 8'd0 : col_q;
	assign scroll  = row_w >= rows_q;

	assign sts.high_byte = byte_q[7];
	assign sts.attr_seq  = (phase_q == PH_ARGS) && (byte_q == CH_ATTR);
	assign sts.attr_last = ((AW+1)'(attr_q) + (AW+1)'(1)) >= (AW+1)'(cnt_q);
	assign sts.console   = console_q;
	assign sts.busy      = busy;

	always_comb begin
		phase_n   = phase_q;
		cnt_n     = cnt_q;
		row_n     = row_q;
		col_n     = col_q;
		saved_n   = saved_q;
		attr_n    = attr_q;
		arg_clr   = 1'b0;
		arg_we    = 1'b0;
		stk_we    = 1'b0;
		mark_last = 1'b0;
		emit_now  = 1'b0;
		emit_last = 1'b0;
		emit_cmd  = CMD_MOVE_CURSOR;
		emit_val  = 16'd0;
		emit_row  = row_q;
		emit_col  = col_q;
		if (cmd.exec && !byte_q[7]) begin
			attr_n = '0;
			case (phase_q)
				PH_TEXT: begin
					if (byte_q == CH_ESC) begin
						arg_clr = 1'b1;
						cnt_n   = '0;
						phase_n = PH_ESC;
					end else if (byte_q == CH_TAB) begin
						if (tab_wrap) begin
							col_n = 8'd0;
							row_n = row_q + 8'd1;
						end else begin
							col_n = tab_t[7:0];
						end
					end else if (byte_q == CH_BS) begin
						if (col_q != 8'd0) begin
							col_n = col_q - 8'd1;
						end
					end else if (byte_q == CH_CR) begin
						col_n = 8'd0;
					end else if (byte_q == CH_LF || byte_q == CH_FF) begin
						col_n = 8'd0;
						row_n = row_q + 8'd1;
					end else if (byte_q >= CH_SPACE) begin
						emit_now = 1'b1;
						emit_cmd = CMD_PUT_CHAR;
						emit_val = {8'd0, byte_q};
						col_n    = col_q + 8'd1;
						if (col_q == 8'hFF) begin
							row_n = row_q + 8'd1;
						end
					end
				end
				PH_ESC: begin
					phase_n = (byte_q == CH_LBRACKET) ? PH_ARGS : PH_TEXT;
				end
				PH_ARGS: begin
					if (byte_q == CH_SEMI && cnt_q != AW'(MAX_ARGUMENTS - 1)) begin
						cnt_n = cnt_q + AW'(1);
					end else if (is_digit) begin
						arg_we = 1'b1;
						if (cnt_q == '0) begin
							cnt_n = AW'(1);
						end
					end else begin
						phase_n = PH_TEXT;
						case (byte_q)
							CH_UP: begin
								row_n = up_row;
							end
							CH_DOWN: begin
								if (dn_ok) begin
									row_n = dn_sum[7:0];
								end
							end
							CH_RIGHT: begin
								if (rt_ok) begin
									col_n = rt_sum[7:0];
								end
							end
							CH_LEFT: begin
								col_n = lf_col;
							end
							CH_NEXTLN: begin
								col_n = 8'd0;
								if (dn_ok) begin
									row_n = dn_sum[7:0];
								end
							end
							CH_PREVLN: begin
								col_n = 8'd0;
								row_n = up_row;
							end
							CH_COLABS: begin
								if (g_ok) begin
									col_n = n_dec0[7:0];
								end
							end
							CH_HOME, CH_HOME_F: begin
								row_n = h_row;
								col_n = h_col;
							end
							CH_SAVE: begin
								if (saved_q != SW'(MAX_SAVED - 1)) begin
									stk_we  = 1'b1;
									saved_n = saved_q + SW'(1);
								end
							end
							CH_RESTORE: begin
								if (saved_q != '0) begin
									saved_n = saved_q - SW'(1);
									row_n   = stk_rd[15:8];
									col_n   = stk_rd[7:0];
								end
							end
							CH_ERASE_LN: begin
								emit_now = 1'b1;
								emit_cmd = CMD_CLEAR_LINE;
								emit_val = args_q[0];
							end
							CH_ERASE_SC: begin
								emit_now = 1'b1;
								emit_cmd = CMD_CLEAR_SCREEN;
								emit_val = args_q[0];
							end
							default: begin
							end
						endcase
					end
				end
				default: begin
					phase_n = PH_TEXT;
				end
			endcase
		end else if (cmd.attr) begin
			emit_now = 1'b1;
			emit_cmd = CMD_SET_ATTR;
			emit_val = arg_rd;
			attr_n   = attr_q + AW'(1);
		end else if (cmd.wrap) begin
			col_n = col_w;
			if (scroll) begin
				emit_now  = 1'b1;
				emit_cmd  = CMD_SCROLL_UP;
				emit_val  = 16'd1;
				emit_row  = row_w;
				emit_col  = col_w;
				emit_last = !console_q;
				row_n     = row_w - 8'd1;
			end else begin
				row_n     = row_w;
				mark_last = !console_q;
			end
		end else if (cmd.move) begin
			emit_now  = 1'b1;
			emit_cmd  = CMD_MOVE_CURSOR;
			emit_last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q      <= COLUMNS_RST;
			rows_q      <= ROWS_RST;
			console_q   <= 1'b1;
			phase_q     <= PH_TEXT;
			cnt_q       <= '0;
			row_q       <= 8'd0;
			col_q       <= 8'd0;
			saved_q     <= '0;
			attr_q      <= '0;
			pend_v_q    <= 1'b0;
			pend_last_q <= 1'b0;
			out_v_q     <= 1'b0;
			for (int i = 0; i < MAX_ARGUMENTS; i++) begin
				args_q[i] <= 16'd0;
			end
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_COLUMNS: cols_q <= wr_data;
					REG_ROWS: rows_q <= wr_data;
					REG_CONSOLE: console_q <= wr_data[0];
					default: begin
					end
				endcase
			end
			phase_q <= phase_n;
			cnt_q   <= cnt_n;
			row_q   <= row_n;
			col_q   <= col_n;
			saved_q <= saved_n;
			attr_q  <= attr_n;
			if (arg_clr) begin
				for (int i = 0; i < MAX_ARGUMENTS; i++) begin
					args_q[i] <= 16'd0;
				end
			end else if (arg_we) begin
				args_q[dig_idx] <= arg_mac;
			end
			if (emit_now) begin
				pend_v_q    <= 1'b1;
				pend_last_q <= emit_last;
			end else if (push) begin
				pend_v_q <= 1'b0;
			end else if (mark_last && pend_v_q) begin
				pend_last_q <= 1'b1;
			end
			if (push) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			byte_q <= text_byte;
		end
		if (stk_we) begin
			stack_q[saved_q] <= {row_q, col_q};
		end
		if (emit_now) begin
			pend_cmd_q <= emit_cmd;
			pend_val_q <= emit_val;
			pend_row_q <= emit_row;
			pend_col_q <= emit_col;
		end
		if (push) begin
			out_cmd_q  <= pend_cmd_q;
			out_val_q  <= pend_val_q;
			out_row_q  <= pend_row_q;
			out_col_q  <= pend_col_q;
			out_last_q <= pend_last_q;
		end
	end

	assign out_valid     = out_v_q;
	assign command       = out_cmd_q;
	assign command_value = out_val_q;
	assign cursor_row    = out_row_q;
	assign cursor_column = out_col_q;
	assign last_command  = out_last_q;

	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		emit_now |-> !busy)
		else $error("result issued with no room in pending stage");

	a_load_clean: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !pend_v_q || pend_last_q)
		else $error("byte taken while previous results unfinished");

	a_saved_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(saved_q) <= MAX_SAVED - 1)
		else $error("save stack count out of range");

endmodule
`default_nettype wire

// ===== sim/ansi_escape_cursor_controller_test.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ANSI escape cursor controller testbench
// Feeds text bytes and ESC [ sequences through the valid/ready text channel
// under several screen setups. An in-bench cursor engine, or for the first
// script bytes a typed table, predicts every display command, which is
// then compared field by field with the result channel. Both sides idle at
// random, and one long receiver hold backs up the block.
// ----------------------------------------------------------------------------
module ansi_escape_cursor_controller_test;
	import aecc_pkg::*;

	typedef struct packed {
		logic [2:0]  command;
		logic [15:0] command_value;
		logic [7:0]  cursor_row;
		logic [7:0]  cursor_column;
		logic        last_command;
	} disp_cmd_t;

	typedef struct packed {
		logic [7:0] text;
		logic       typed;
		logic [1:0] n_typed;
		disp_cmd_t  first;
		disp_cmd_t  second;
	} script_row_t;

	localparam disp_cmd_t NO_CMD = '0;
	localparam int SCRIPT_LEN = 33;
	localparam int SETTLE_CYCLES = 24;
	localparam int SETTLE_LIMIT = 5000;

	localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
		'{CH_SPACE, 1'b1, 2'd2, '{CMD_PUT_CHAR, 16'h0020, 8'd0, 8'd0, 1'b0},
			'{CMD_MOVE_CURSOR, 16'd0, 8'd0, 8'd1, 1'b1}},
		'{8'h7F, 1'b1, 2'd2, '{CMD_PUT_CHAR, 16'h007F, 8'd0, 8'd1, 1'b0},
			'{CMD_MOVE_CURSOR, 16'd0, 8'd0, 8'd2, 1'b1}},
		'{8'h80, 1'b1, 2'd0, NO_CMD, NO_CMD},
		'{8'hFF, 1'b1, 2'd0, NO_CMD, NO_CMD},
		'{8'h07, 1'b1, 2'd1, '{CMD_MOVE_CURSOR, 16'd0, 8'd0, 8'd2, 1'b1}, NO_CMD},
		'{CH_BS, 1'b1, 2'd1, '{CMD_MOVE_CURSOR, 16'd0, 8'd0, 8'd1, 1'b1}, NO_CMD},
		'{CH_TAB, 1'b1, 2'd1, '{CMD_MOVE_CURSOR, 16'd0, 8'd0, 8'd8, 1'b1}, NO_CMD},
		'{CH_CR, 1'b1, 2'd1, '{CMD_MOVE_CURSOR, 16'd0, 8'd0, 8'd0, 1'b1}, NO_CMD},
		'{CH_BS, 1'b1, 2'd1, '{CMD_MOVE_CURSOR, 16'd0, 8'd0, 8'd0, 1'b1}, NO_CMD},
		'{CH_LF, 1'b1, 2'd1, '{CMD_MOVE_CURSOR, 16'd0, 8'd1, 8'd0, 1'b1}, NO_CMD},
		'{CH_FF, 1'b1, 2'd1, '{CMD_MOVE_CURSOR, 16'd0, 8'd2, 8'd0, 1'b1}, NO_CMD},
		'{8'h00, 1'b1, 2'd1, '{CMD_MOVE_CURSOR, 16'd0, 8'd2, 8'd0, 1'b1}, NO_CMD},
		'{CH_ESC, 1'b1, 2'd1, '{CMD_MOVE_CURSOR, 16'd0, 8'd2, 8'd0, 1'b1}, NO_CMD},
		'{8'h78, 1'b0, 2'd0, NO_CMD, NO_CMD},
		'{CH_ESC, 1'b0, 2'd0, NO_CMD, NO_CMD},
		'{CH_LBRACKET, 1'b0, 2'd0, NO_CMD, NO_CMD},
		'{CH_NINE, 1'b0, 2'd0, NO_CMD, NO_CMD},
		'{CH_NINE, 1'b0, 2'd0, NO_CMD, NO_CMD},
		'{CH_NINE, 1'b0, 2'd0, NO_CMD, NO_CMD},
		'{CH_NINE, 1'b0, 2'd0, NO_CMD, NO_CMD},
		'{CH_NINE, 1'b0, 2'd0, NO_CMD, NO_CMD},
		'{CH_ERASE_LN, 1'b0, 2'd0, NO_CMD, NO_CMD},
		'{CH_ESC, 1'b0, 2'd0, NO_CMD, NO_CMD},
		'{CH_LBRACKET, 1'b0, 2'd0, NO_CMD, NO_CMD},
		'{CH_SEMI, 1'b0, 2'd0, NO_CMD, NO_CMD},
		'{CH_SEMI, 1'b0, 2'd0, NO_CMD, NO_CMD},
		'{CH_SEMI, 1'b0, 2'd0, NO_CMD, NO_CMD},
		'{CH_SEMI, 1'b0, 2'd0, NO_CMD, NO_CMD},
		'{CH_SEMI, 1'b0, 2'd0, NO_CMD, NO_CMD},
		'{CH_SEMI, 1'b0, 2'd0, NO_CMD, NO_CMD},
		'{CH_SEMI, 1'b0, 2'd0, NO_CMD, NO_CMD},
		'{CH_SEMI, 1'b0, 2'd0, NO_CMD, NO_CMD},
		'{CH_ATTR, 1'b0, 2'd0, NO_CMD, NO_CMD}
	};

	localparam logic [7:0] FINALS [14] = '{
		CH_UP, CH_DOWN, CH_RIGHT, CH_LEFT, CH_NEXTLN, CH_PREVLN, CH_COLABS,
		CH_HOME, CH_HOME_F, CH_SAVE, CH_RESTORE, CH_ERASE_LN, CH_ERASE_SC, CH_ATTR
	};

	logic                  clk;
	logic                  arst_n;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	aecc_text_if   txt ();
	aecc_result_if res ();

	ansi_escape_cursor_controller i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.text     (txt),
		.result   (res)
	);

	// cursor engine state
	logic [7:0]  scr_cols;
	logic [7:0]  scr_rows;
	logic        console_on;
	phase_t      esc_ph;
	logic [3:0]  arg_cnt;
	logic [15:0] arg_val [MAX_ARGUMENTS_DEF];
	logic [7:0]  cur_row;
	logic [7:0]  cur_col;
	logic [15:0] save_stack [MAX_SAVED_DEF];
	logic [3:0]  save_depth;

	disp_cmd_t   step_cmds [$];
	disp_cmd_t   expected_cmds [$];

	int unsigned tx_gap_max = 7;
	int unsigned rx_gap_max = 7;
	int unsigned rx_hold = 0;
	int unsigned csi_seen = 0;
	int unsigned bytes_fed = 0;
	int unsigned high_dropped = 0;
	int unsigned cmds_checked = 0;
	int unsigned mismatches = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin : watchdog
		#4000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic void issue(logic [2:0] cmd, logic [15:0] val);
		disp_cmd_t c;
		c.command = cmd;
		c.command_value = val;
		c.cursor_row = cur_row;
		c.cursor_column = cur_col;
		c.last_command = 1'b0;
		step_cmds.push_back(c);
	endfunction

	function automatic void predict_byte(logic [7:0] b);
		int unsigned t;
		int unsigned n;
		int unsigned lim;
		step_cmds.delete();
		if (b[7])
			return;
		case (esc_ph)
			PH_TEXT: begin
				if (b == CH_ESC) begin
					arg_cnt = '0;
					foreach (arg_val[j])
						arg_val[j] = '0;
					esc_ph = PH_ESC;
				end else if (b == CH_TAB) begin
					t = (cur_col + 32'd8) & ~32'd7;
					if (t >= scr_cols) begin
						cur_col = '0;
						cur_row = cur_row + 8'd1;
					end else
						cur_col = t[7:0];
				end else if (b == CH_BS) begin
					if (cur_col != 0)
						cur_col = cur_col - 8'd1;
				end else if (b == CH_CR) begin
					cur_col = '0;
				end else if (b == CH_LF || b == CH_FF) begin
					cur_col = '0;
					cur_row = cur_row + 8'd1;
				end else if (b >= CH_SPACE) begin
					issue(CMD_PUT_CHAR, {8'd0, b});
					cur_col = cur_col + 8'd1;
					if (cur_col == 0)
						cur_row = cur_row + 8'd1;
				end
			end
			PH_ESC: esc_ph = (b == CH_LBRACKET) ? PH_ARGS : PH_TEXT;
			default: begin
				if (b == CH_SEMI && arg_cnt < MAX_ARGUMENTS_DEF - 1) begin
					arg_cnt = arg_cnt + 4'd1;
				end else if (b >= CH_ZERO && b <= CH_NINE) begin
					if (arg_cnt == 0)
						arg_cnt = 4'd1;
					arg_val[arg_cnt-1] = arg_val[arg_cnt-1] * 16'd10 + {8'd0, b - CH_ZERO};
				end else begin
					n = (arg_val[0] != 0) ? 32'(arg_val[0]) : 1;
					case (b)
						CH_UP: cur_row = (cur_row >= n) ? 8'(cur_row - n) : 8'd0;
						CH_DOWN: begin
							if (cur_row + n < scr_rows)
								cur_row = 8'(cur_row + n);
						end
						CH_RIGHT: begin
							if (cur_col + n < scr_cols)
								cur_col = 8'(cur_col + n);
						end
						CH_LEFT: cur_col = (cur_col >= n) ? 8'(cur_col - n) : 8'd0;
						CH_NEXTLN: begin
							cur_col = '0;
							if (cur_row + n < scr_rows)
								cur_row = 8'(cur_row + n);
						end
						CH_PREVLN: begin
							cur_col = '0;
							cur_row = (cur_row >= n) ? 8'(cur_row - n) : 8'd0;
						end
						CH_COLABS: begin
							t = 32'(arg_val[0]);
							if (t != 0)
								t = t - 1;
							if (t < scr_cols)
								cur_col = t[7:0];
						end
						CH_HOME, CH_HOME_F: begin
							t = 32'(arg_val[0]);
							if (t != 0)
								t = t - 1;
							lim = (scr_rows != 0) ? scr_rows - 1 : 0;
							cur_row = (t > lim) ? lim[7:0] : t[7:0];
							t = 32'(arg_val[1]);
							if (t != 0)
								t = t - 1;
							lim = (scr_cols != 0) ? scr_cols - 1 : 0;
							cur_col = (t > lim) ? lim[7:0] : t[7:0];
						end
						CH_SAVE: begin
							if (save_depth < MAX_SAVED_DEF - 1) begin
								save_stack[save_depth] = {cur_row, cur_col};
								save_depth = save_depth + 4'd1;
							end
						end
						CH_RESTORE: begin
							if (save_depth != 0) begin
								save_depth = save_depth - 4'd1;
								{cur_row, cur_col} = save_stack[save_depth];
							end
						end
						CH_ERASE_LN: issue(CMD_CLEAR_LINE, arg_val[0]);
						CH_ERASE_SC: issue(CMD_CLEAR_SCREEN, arg_val[0]);
						CH_ATTR: begin
							if (arg_cnt == 0)
								issue(CMD_SET_ATTR, 16'd0);
							else
								for (int i = 0; i < arg_cnt; i++)
									issue(CMD_SET_ATTR, arg_val[i]);
						end
						default: ;
					endcase
					esc_ph = PH_TEXT;
				end
			end
		endcase

		if (cur_col >= scr_cols) begin
			cur_col = '0;
			cur_row = cur_row + 8'd1;
		end
		if (cur_row >= scr_rows) begin
			issue(CMD_SCROLL_UP, 16'd1);
			cur_row = cur_row - 8'd1;
		end
		if (console_on)
			issue(CMD_MOVE_CURSOR, 16'd0);
		if (step_cmds.size() != 0)
			step_cmds[step_cmds.size()-1].last_command = 1'b1;
	endfunction

	task automatic send_text(logic [7:0] b);
		int unsigned gap;
		gap = $urandom_range(0, tx_gap_max);
		if (gap != 0) begin
			txt.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		txt.valid <= 1'b1;
		txt.text_byte <= b;
		do
			@(posedge clk);
		while (!(txt.valid && txt.ready));
		bytes_fed++;
		if (b[7])
			high_dropped++;
	endtask

	task automatic feed(logic [7:0] b);
		send_text(b);
		predict_byte(b);
		foreach (step_cmds[i])
			expected_cmds.push_back(step_cmds[i]);
	endtask

	task automatic settle();
		txt.valid <= 1'b0;
		for (int w = 0; w < SETTLE_LIMIT && expected_cmds.size() != 0; w++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_screen(logic [7:0] cols, logic [7:0] rows, logic con);
		wr_en <= 1'b1;
		wr_index <= REG_COLUMNS;
		wr_data <= cols;
		@(posedge clk);
		wr_index <= REG_ROWS;
		wr_data <= rows;
		@(posedge clk);
		wr_index <= REG_CONSOLE;
		wr_data <= {{(CFG_DATA_W-1){1'b0}}, con};
		@(posedge clk);
		wr_en <= 1'b0;
		scr_cols = cols;
		scr_rows = rows;
		console_on = con;
	endtask

	task automatic random_stretch(int unsigned target);
		logic [7:0]  burst [$];
		logic [7:0]  fin;
		int unsigned counted;
		int unsigned kind;
		int unsigned nargs;
		int unsigned ndig;
		counted = 0;
		while (counted < target) begin
			burst.delete();
			kind = $urandom_range(0, 19);
			if (kind < 12) begin
				fin = (csi_seen < 14) ? FINALS[csi_seen] : FINALS[$urandom_range(0, 13)];
				csi_seen++;
				burst.push_back(CH_ESC);
				burst.push_back(CH_LBRACKET);
				nargs = (fin == CH_ATTR) ? $urandom_range(0, 8) : $urandom_range(0, 2);
				for (int a = 0; a < nargs; a++) begin
					if (a != 0)
						burst.push_back(CH_SEMI);
					ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 5) : $urandom_range(0, 2);
					repeat (ndig) burst.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
				end
				burst.push_back(fin);
			end else if (kind < 17) begin
				repeat ($urandom_range(1, 6)) begin
					case ($urandom_range(0, 9))
						0: burst.push_back(CH_TAB);
						1: burst.push_back(CH_BS);
						2: burst.push_back(CH_CR);
						3: burst.push_back(CH_LF);
						4: burst.push_back(CH_FF);
						5: burst.push_back(8'($urandom_range(0, 31)));
						default: burst.push_back(8'($urandom_range(32, 127)));
					endcase
				end
			end else if (kind == 17) begin
				burst.push_back(8'($urandom_range(128, 255)));
			end else if (kind == 18) begin
				burst.push_back(CH_ESC);
				if ($urandom_range(0, 1) == 0) begin
					burst.push_back(8'($urandom_range(0, 255)));
				end else begin
					burst.push_back(CH_LBRACKET);
					repeat ($urandom_range(0, 2)) burst.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
					burst.push_back(8'($urandom_range(0, 127)));
				end
			end else begin
				fin = ($urandom_range(0, 1) == 0) ? CH_SAVE : CH_RESTORE;
				repeat (MAX_SAVED_DEF) begin
					burst.push_back(CH_ESC);
					burst.push_back(CH_LBRACKET);
					burst.push_back(fin);
				end
			end
			foreach (burst[i]) begin
				feed(burst[i]);
				if (!burst[i][7])
					counted++;
			end
		end
	endtask

	initial begin : result_sink
		int unsigned stall;
		disp_cmd_t   want;
		res.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = (rx_hold != 0) ? rx_hold : $urandom_range(0, rx_gap_max);
			rx_hold = 0;
			if (stall != 0) begin
				res.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res.ready <= 1'b1;
			do
				@(posedge clk);
			while (!(res.valid && res.ready));
			cmds_checked++;
			if (expected_cmds.size() == 0) begin
				$error("display command %0d at %0d,%0d with nothing expected",
					res.command, res.cursor_row, res.cursor_column);
				mismatches++;
			end else begin
				want = expected_cmds.pop_front();
				if (res.command !== want.command) begin
					$error("command: expected %0d, got %0d", want.command, res.command);
					mismatches++;
				end
				if (res.command_value !== want.command_value) begin
					$error("command_value: expected %0d, got %0d",
						want.command_value, res.command_value);
					mismatches++;
				end
				if (res.cursor_row !== want.cursor_row) begin
					$error("cursor_row: expected %0d, got %0d", want.cursor_row, res.cursor_row);
					mismatches++;
				end
				if (res.cursor_column !== want.cursor_column) begin
					$error("cursor_column: expected %0d, got %0d",
						want.cursor_column, res.cursor_column);
					mismatches++;
				end
				if (res.last_command !== want.last_command) begin
					$error("last_command: expected %0d, got %0d",
						want.last_command, res.last_command);
					mismatches++;
				end
			end
		end
	end

	initial begin : stimulus
		arst_n <= 1'b0;
		wr_en <= 1'b0;
		wr_index <= '0;
		wr_data <= '0;
		txt.valid <= 1'b0;
		txt.text_byte <= '0;

		scr_cols = COLUMNS_RST;
		scr_rows = ROWS_RST;
		console_on = 1'b1;
		esc_ph = PH_TEXT;
		arg_cnt = '0;
		foreach (arg_val[j])
			arg_val[j] = '0;
		cur_row = '0;
		cur_col = '0;
		save_depth = '0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < SCRIPT_LEN; i++) begin
			if (SCRIPT[i].typed) begin
				send_text(SCRIPT[i].text);
				predict_byte(SCRIPT[i].text);
				if (SCRIPT[i].n_typed > 0)
					expected_cmds.push_back(SCRIPT[i].first);
				if (SCRIPT[i].n_typed > 1)
					expected_cmds.push_back(SCRIPT[i].second);
			end else
				feed(SCRIPT[i].text);
		end
		random_stretch(45);
		settle();

		// smallest screen: every printed byte wraps and scrolls
		set_screen(8'd1, 8'd1, 1'b1);
		tx_gap_max = 0;
		rx_gap_max = 0;
		random_stretch(30);
		settle();

		set_screen(8'd255, 8'd255, 1'b0);
		tx_gap_max = 7;
		rx_gap_max = 0;
		random_stretch(40);
		settle();

		// hold the result side long enough to back up the text channel
		set_screen(8'd10, 8'd4, 1'b1);
		tx_gap_max = 0;
		rx_gap_max = 7;
		rx_hold = 300;
		random_stretch(45);
		settle();

		set_screen(8'd255, 8'd1, 1'b1);
		tx_gap_max = 7;
		rx_gap_max = 7;
		random_stretch(35);
		settle();

		if (expected_cmds.size() != 0) begin
			$error("%0d display commands never arrived", expected_cmds.size());
			mismatches += expected_cmds.size();
		end

		$display("Fed %0d text bytes (%0d high bytes dropped) over five screen setups,",
			bytes_fed, high_dropped);
		$display("%0d display commands compared, %0d errors found.", cmds_checked, mismatches);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
`default_nettype wire
